@@ sv/npc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the nearest palette color search.
package npc_pkg;

  localparam int PaletteDepth = 256;
  localparam int IdxW         = $clog2(PaletteDepth);
  localparam int CountW       = $clog2(PaletteDepth + 1);
  localparam int CfgW         = 9;
  localparam int CompW        = 16;
  localparam int ByteW        = 8;
  localparam int SqW          = 2 * ByteW;
  localparam int DistW        = SqW + 2;
  localparam int QueueDepth   = 4;
  localparam int QPtrW        = $clog2(QueueDepth);
  localparam int QCntW        = $clog2(QueueDepth + 1);

  typedef enum logic {
    ReqLoad  = 1'b0,
    ReqQuery = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } color_t;

  typedef struct packed {
    req_kind_e       kind;
    logic [IdxW-1:0] index;
    color_t          color;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StDrain = 3'b100
  } back_state_e;

endpackage

@@ sv/npc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts transactions, classifies them and packs them for the queue.
module npc_front import npc_pkg::*; (
  input  logic              start_i,
  input  logic              req_type_i,
  input  logic [IdxW-1:0]   entry_index_i,
  input  logic [CompW-1:0]  red_i,
  input  logic [CompW-1:0]  green_i,
  input  logic [CompW-1:0]  blue_i,
  input  queue_status_t     q_status_i,
  output logic              push_o,
  output req_t              push_req_o,
  output logic              busy_o
);

  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full;

  always_comb begin
    push_req_o.kind        = req_kind_e'(req_type_i);
    push_req_o.index       = entry_index_i;
    push_req_o.color.red   = red_i[CompW-1 -: ByteW];
    push_req_o.color.green = green_i[CompW-1 -: ByteW];
    push_req_o.color.blue  = blue_i[CompW-1 -: ByteW];
  end

endmodule

@@ sv/npc_queue.sv @@
`timescale 1ns / 1ps
// Short request queue between the front end and the search engine.
module npc_queue import npc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  req_t          push_req_i,
  input  logic          pop_i,
  output req_t          head_o,
  output queue_status_t status_o
);

  req_t             entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign status_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ sv/npc_back.sv @@
`timescale 1ns / 1ps
// Search engine: palette memory, palette loads and the nearest entry scan.
module npc_back import npc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CfgW-1:0]   palette_size_i,
  input  req_t              head_i,
  input  queue_status_t     q_status_i,
  output logic              pop_o,
  output logic              done_o,
  output logic [IdxW-1:0]   nearest_index_o
);

  logic [3*ByteW-1:0] mem_q [PaletteDepth];

  back_state_e       state_q;
  logic [IdxW-1:0]   rd_addr_q, last_addr_q;
  color_t            color_q;
  logic              rd_en;
  logic              mem_we;
  logic [CountW-1:0] count_capped;

  logic [3*ByteW-1:0] rd_data_q;
  logic               s1_valid_q;
  logic [IdxW-1:0]    s1_idx_q;
  color_t             entry;
  logic [ByteW-1:0]   diff_r, diff_g, diff_b;

  logic               s2_valid_q;
  logic [IdxW-1:0]    s2_idx_q;
  logic [SqW-1:0]     sq_r_q, sq_g_q, sq_b_q;
  logic [DistW-1:0]   dist_sum;

  logic [DistW-1:0]   best_q;
  logic [IdxW-1:0]    best_idx_q;
  logic               done_q;
  logic [IdxW-1:0]    result_q;

  assign pop_o  = (state_q == StIdle) && !q_status_i.empty;
  assign mem_we = pop_o && (head_i.kind == ReqLoad);
  assign rd_en  = (state_q == StScan);

  always_comb begin
    if (32'(palette_size_i) > 32'(PaletteDepth)) begin
      count_capped = CountW'(PaletteDepth);
    end else begin
      count_capped = CountW'(palette_size_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_i.index] <= head_i.color;
    end
    rd_data_q <= mem_q[rd_addr_q];
  end

  assign entry  = color_t'(rd_data_q);
  assign diff_r = (color_q.red > entry.red) ? (color_q.red - entry.red)
                                            : (entry.red - color_q.red);
  assign diff_g = (color_q.green > entry.green) ? (color_q.green - entry.green)
                                                : (entry.green - color_q.green);
  assign diff_b = (color_q.blue > entry.blue) ? (color_q.blue - entry.blue)
                                              : (entry.blue - color_q.blue);

  always_ff @(posedge clk_i) begin
    s1_idx_q <= rd_addr_q;
    s2_idx_q <= s1_idx_q;
    sq_r_q   <= diff_r * diff_r;
    sq_g_q   <= diff_g * diff_g;
    sq_b_q   <= diff_b * diff_b;
  end

  assign dist_sum = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_addr_q   <= '0;
      last_addr_q <= '0;
      color_q     <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      best_q      <= '0;
      best_idx_q  <= '0;
      done_q      <= 1'b0;
      result_q    <= '0;
    end else begin
      done_q     <= 1'b0;
      s1_valid_q <= rd_en;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q && ((s2_idx_q == '0) || (dist_sum < best_q))) begin
        best_q     <= dist_sum;
        best_idx_q <= s2_idx_q;
      end
      case (state_q)
        StIdle: begin
          if (pop_o && (head_i.kind == ReqQuery)) begin
            color_q <= head_i.color;
            if (count_capped == '0) begin
              done_q   <= 1'b1;
              result_q <= '0;
            end else begin
              last_addr_q <= IdxW'(count_capped - CountW'(1));
              rd_addr_q   <= '0;
              state_q     <= StScan;
            end
          end
        end
        StScan: begin
          if (rd_addr_q == last_addr_q) begin
            state_q <= StDrain;
          end else begin
            rd_addr_q <= rd_addr_q + IdxW'(1);
          end
        end
        StDrain: begin
          if (!s1_valid_q && !s2_valid_q) begin
            done_q   <= 1'b1;
            result_q <= best_idx_q;
            state_q  <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign nearest_index_o = result_q;

endmodule

@@ sv/nearest_palette_color.sv @@
`timescale 1ns / 1ps
// Nearest palette color search: a four-deep queue feeds a scan engine that reads one entry
// per cycle. For a query popped by the idle engine it reads the first N entries, N being the
// capped palette size, and raises done_o once the pipeline has drained, or without a scan when
// N is 0. A query holds the engine until done; a load leaves it idle. busy rises only with
// the queue full. done_o is a one-cycle strobe that the receiver cannot stall. Reset clears
// control state and sets the palette size to 256; palette contents are undefined until loaded.
module nearest_palette_color import npc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              req_type_i,
  input  logic [IdxW-1:0]   entry_index_i,
  input  logic [CompW-1:0]  red_i,
  input  logic [CompW-1:0]  green_i,
  input  logic [CompW-1:0]  blue_i,
  output logic              done_o,
  output logic [IdxW-1:0]   nearest_index_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgW-1:0]   cfg_data_i
);

  logic            push, pop;
  req_t            push_req, head;
  queue_status_t   q_status;
  logic [CfgW-1:0] palette_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= CfgW'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      palette_size_q <= cfg_data_i;
    end
  end

  npc_front u_front (
    .start_i       (start),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_req_o    (push_req),
    .busy_o        (busy)
  );

  npc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  npc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .palette_size_i  (palette_size_q),
    .head_i          (head),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .done_o          (done_o),
    .nearest_index_o (nearest_index_o)
  );

endmodule
